// ===== sv/npr_pkg.sv =====
package npr_pkg;

	// Page geometry. The column is the address bits below the page size.
	localparam int unsigned PAGE_BYTES = 2048;
	localparam int unsigned COL_W = $clog2(PAGE_BYTES);

	// Depth of the job queue between the front and back ends (a power of two).
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CMD_READ = 8'h00;
	localparam logic [7:0] CMD_READSTART = 8'h30;

	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_READY = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OP_SELECT = 3'd0,
		OP_CMD = 3'd1,
		OP_ADDR = 3'd2,
		OP_DATA = 3'd3,
		OP_DESELECT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_READ = 2'd2
	} phase_t;

	// What follows the first result of a job.
	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_DESEL = 2'd1,
		TAIL_PAGE = 2'd2
	} tail_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] start_address;
		logic [31:0] length;
		logic [7:0] flash_byte;
	} req_t;

	typedef struct packed {
		op_t op;
		logic [7:0] byte_value;
		logic [31:0] buffer_index;
		logic last;
	} rsp_t;

	// One classified transaction. The first result is a data byte or a chip
	// select; the tail adds a deselect or a full page command sequence.
	typedef struct packed {
		logic first_data;
		tail_t tail;
		logic [7:0] data;
		logic [31:0] index;
		logic [31:0] addr;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

endpackage

// ===== sv/nand_page_read_sequencer.sv =====
// An accepted request or data byte is written into the job queue and then into the output register.
// One transaction is taken per cycle while the queue has room; results leave one per cycle unless
// stalled. A final byte adds a deselect, a page turn the page commands, a request either of them.
// A four-entry job queue lets input keep flowing while a command burst drains.
// Reset (arst_n, asynchronous, active low) returns the sequencer to idle with all counters clear
// and the queue and output register empty.
module nand_page_read_sequencer (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input npr_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output npr_pkg::rsp_t rsp
);

	// The front end owns the sequencing state: phase, flash address, column,
	// bytes read and run length. Every input transaction is classified there
	// and, when it causes results, turned into one compact job. Transactions
	// that arrive in the wrong phase are accepted and dropped.
	npr_pkg::job_push_t wr;
	npr_pkg::job_t head;
	logic full;
	logic empty;
	logic pop;
	logic take;

	// The front end can always take a transaction while the queue has room,
	// independent of whether the output side is stalled.
	assign req_ready = !full;
	assign take = req_valid && req_ready;

	npr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.req(req),
		.wr(wr)
	);

	// The queue decouples classification from expansion, so a long page
	// command burst on the output does not hold back incoming data bytes
	// until the queue fills.
	npr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head(head)
	);

	// The back end walks each job one result per cycle, unless rsp_ready stalls it, into a registered
	// output stage: chip select or data byte first, then, if the job has a tail, either a deselect
	// or the read command, five address bytes and the read-start command.
	// The job leaves the queue with its last result, so single-result jobs
	// stream at full rate.
	npr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

// ===== sv/npr_front.sv =====
module npr_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input npr_pkg::req_t req,
	output npr_pkg::job_push_t wr
);

	npr_pkg::phase_t phase_q, phase_d;
	logic [31:0] addr_q, addr_d;
	logic [31:0] done_q, done_d;
	logic [31:0] total_q, total_d;
	logic [npr_pkg::COL_W-1:0] col_q, col_d;
	logic [31:0] done_inc;
	logic [31:0] addr_inc;

	assign done_inc = done_q + 32'd1;
	assign addr_inc = addr_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= npr_pkg::PH_IDLE;
			addr_q <= '0;
			done_q <= '0;
			total_q <= '0;
			col_q <= '0;
		end else begin
			phase_q <= phase_d;
			addr_q <= addr_d;
			done_q <= done_d;
			total_q <= total_d;
			col_q <= col_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		addr_d = addr_q;
		done_d = done_q;
		total_d = total_q;
		col_d = col_q;
		wr = '0;
		wr.job.tail = npr_pkg::TAIL_NONE;
		if (take) begin
			case (req.kind)
				npr_pkg::KIND_REQUEST: begin
					if (phase_q == npr_pkg::PH_IDLE) begin
						wr.push = 1'b1;
						wr.job.addr = req.start_address;
						addr_d = req.start_address;
						total_d = req.length;
						done_d = '0;
						col_d = req.start_address[npr_pkg::COL_W-1:0];
						if (req.length == 32'd0) begin
							wr.job.tail = npr_pkg::TAIL_DESEL;
						end else begin
							wr.job.tail = npr_pkg::TAIL_PAGE;
							phase_d = npr_pkg::PH_WAIT;
						end
					end
				end
				npr_pkg::KIND_READY: begin
					if (phase_q == npr_pkg::PH_WAIT) begin
						phase_d = npr_pkg::PH_READ;
					end
				end
				npr_pkg::KIND_DATA: begin
					if (phase_q == npr_pkg::PH_READ) begin
						wr.push = 1'b1;
						wr.job.first_data = 1'b1;
						wr.job.data = req.flash_byte;
						wr.job.index = done_q;
						wr.job.addr = addr_inc;
						done_d = done_inc;
						addr_d = addr_inc;
						if (done_inc == total_q) begin
							wr.job.tail = npr_pkg::TAIL_DESEL;
							phase_d = npr_pkg::PH_IDLE;
							col_d = '0;
						end else if (col_q == npr_pkg::COL_W'(npr_pkg::PAGE_BYTES - 1)) begin
							wr.job.tail = npr_pkg::TAIL_PAGE;
							phase_d = npr_pkg::PH_WAIT;
							col_d = '0;
						end else begin
							col_d = col_q + npr_pkg::COL_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A run in progress always has bytes left to read.
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != npr_pkg::PH_IDLE) |-> (done_q != total_q))
		else $error("front busy with no bytes remaining");

	// A ready event never produces a job.
	a_ready_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(take && req.kind == npr_pkg::KIND_READY) |-> !wr.push)
		else $error("ready event pushed a job");

	// The column always tracks the address within its page while reading.
	a_col_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == npr_pkg::PH_READ) |-> (col_q == addr_q[npr_pkg::COL_W-1:0]))
		else $error("column out of step with address");

endmodule

// ===== sv/npr_queue.sv =====
module npr_queue (
	input logic clk,
	input logic arst_n,
	input npr_pkg::job_push_t wr,
	input logic pop,
	output logic full,
	output logic empty,
	output npr_pkg::job_t head
);

	npr_pkg::job_t entry_q [npr_pkg::QUEUE_DEPTH];
	logic [npr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [npr_pkg::QPTR_W:0] count_q;

	assign full = (count_q == (npr_pkg::QPTR_W + 1)'(npr_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			entry_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + npr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + npr_pkg::QPTR_W'(1);
			end
			case ({wr.push, pop})
				2'b10: count_q <= count_q + (npr_pkg::QPTR_W + 1)'(1);
				2'b01: count_q <= count_q - (npr_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (npr_pkg::QPTR_W + 1)'(npr_pkg::QUEUE_DEPTH))
		else $error("job queue count out of range");

endmodule

// ===== sv/npr_back.sv =====
module npr_back (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input npr_pkg::job_t head,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_ready,
	output npr_pkg::rsp_t rsp
);

	logic [2:0] step_q;
	logic rsp_valid_q;
	npr_pkg::rsp_t rsp_q;
	logic load;
	logic [2:0] last_step;
	npr_pkg::rsp_t item;
	logic [15:0] col;
	logic [31:0] page;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign load = !empty && (!rsp_valid_q || rsp_ready);
	assign col = 16'(head.addr[npr_pkg::COL_W-1:0]);
	assign page = head.addr >> npr_pkg::COL_W;

	always_comb begin
		case (head.tail)
			npr_pkg::TAIL_DESEL: last_step = 3'd1;
			npr_pkg::TAIL_PAGE: last_step = 3'd7;
			default: last_step = 3'd0;
		endcase

		item = '0;
		item.op = npr_pkg::OP_SELECT;
		if (step_q == 3'd0) begin
			if (head.first_data) begin
				item.op = npr_pkg::OP_DATA;
				item.byte_value = head.data;
				item.buffer_index = head.index;
			end
		end else if (head.tail == npr_pkg::TAIL_DESEL) begin
			item.op = npr_pkg::OP_DESELECT;
		end else begin
			case (step_q)
				3'd1: begin
					item.op = npr_pkg::OP_CMD;
					item.byte_value = npr_pkg::CMD_READ;
				end
				3'd2: begin
					item.op = npr_pkg::OP_ADDR;
					item.byte_value = col[7:0];
				end
				3'd3: begin
					item.op = npr_pkg::OP_ADDR;
					item.byte_value = col[15:8];
				end
				3'd4: begin
					item.op = npr_pkg::OP_ADDR;
					item.byte_value = page[7:0];
				end
				3'd5: begin
					item.op = npr_pkg::OP_ADDR;
					item.byte_value = page[15:8];
				end
				3'd6: begin
					item.op = npr_pkg::OP_ADDR;
					item.byte_value = page[23:16];
				end
				default: begin
					item.op = npr_pkg::OP_CMD;
					item.byte_value = npr_pkg::CMD_READSTART;
				end
			endcase
		end
		item.last = (step_q == last_step);
		pop = load && item.last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (pop) begin
				step_q <= '0;
			end else if (load) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// The step counter never runs past the end of the current job.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (step_q <= last_step))
		else $error("step counter beyond end of job");

	// A job is retired only together with its final result.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (rsp_valid_q && rsp_q.last))
		else $error("job retired without final result");

endmodule
